### hdl/cia_pkg.sv
// shared types and constants for the checked 64-bit alu
// no dependencies; used by every module under hdl
`timescale 1ns / 1ps

package cia_pkg;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned HALF_W = DATA_W / 2;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // item travelling down the pipeline
    typedef struct packed {
        op_t                opcode;
        logic               neg;     // result sign for mul and div
        logic               ovf;
        logic               dbz;
        logic [DATA_W-1:0]  mag_a;   // magnitude of a; divider shifts it into the quotient
        logic [DATA_W-1:0]  mag_b;   // magnitude of b
        logic [DATA_W-1:0]  value;   // sum, difference, unsigned product or unsigned quotient
    } item_t;

endpackage

### hdl/checked_int64_alu_unit.sv
// top level of the checked signed 64-bit alu: operand prep, multiplier, divider, output stage
// depends on cia_pkg, cia_mul and cia_div
`timescale 1ns / 1ps

// Signed 64-bit add, subtract, multiply and divide (quotient truncated toward zero) with
// overflow and divide-by-zero flags; a flagged result always reads as zero, and a zero divisor
// sets divide-by-zero only. Every item, whatever its opcode, runs through the same 69-stage
// pipeline: one prep stage (magnitudes, add and subtract), three multiplier stages built from
// four 32x32 partial products, sixty-four restoring divider stages giving one quotient bit each,
// and the output register. One item can be taken every cycle while the pipeline is not held.
// The whole pipeline advances together; it holds only while a result waits in the output
// register and m_tready is low, and s_tready follows that hold.
module checked_int64_alu_unit
    import cia_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // operand_a [63:0], operand_b [127:64]
    input  logic [1:0]   s_tuser,   // opcode [1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // value [63:0]
    output logic [1:0]   m_tuser    // overflow [0], divide_by_zero [1]
);

    localparam logic [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};

    // global advance
    logic en;

    // prep stage
    logic              prep_v_reg;
    item_t             prep_reg;
    item_t             prep_next;
    logic [DATA_W-1:0] a, b, sum, diff;

    // between units
    logic  mul_v, div_v;
    item_t mul_item, div_item;

    // output register
    logic              out_v_reg;
    logic [DATA_W-1:0] out_value_reg, out_value_next;
    logic              out_ovf_reg, out_dbz_reg;

    assign en       = !out_v_reg || m_tready;
    assign s_tready = en;

    assign a = s_tdata[DATA_W-1:0];
    assign b = s_tdata[2*DATA_W-1:DATA_W];

    // operand prep: add and subtract finish here, others get magnitudes and sign
    always_comb
    begin
        sum  = a + b;
        diff = a - b;
        prep_next.opcode = op_t'(s_tuser);
        prep_next.neg    = a[DATA_W-1] ^ b[DATA_W-1];
        prep_next.mag_a  = a[DATA_W-1] ? -a : a;
        prep_next.mag_b  = b[DATA_W-1] ? -b : b;
        prep_next.value  = '0;
        prep_next.ovf    = 1'b0;
        prep_next.dbz    = 1'b0;
        unique case (op_t'(s_tuser))
            OP_ADD:
            begin
                prep_next.value = sum;
                prep_next.ovf   = (a[DATA_W-1] == b[DATA_W-1])
                                && (sum[DATA_W-1] != a[DATA_W-1]);
            end
            OP_SUB:
            begin
                prep_next.value = diff;
                prep_next.ovf   = (a[DATA_W-1] != b[DATA_W-1])
                                && (diff[DATA_W-1] != a[DATA_W-1]);
            end
            OP_MUL:
            begin
                prep_next.ovf = 1'b0;
            end
            OP_DIV:
            begin
                // most negative over minus one is the one overflowing quotient
                prep_next.dbz = (b == '0);
                prep_next.ovf = (a == MIN_VAL) && (b == '1);
            end
            default:
            begin
                prep_next.ovf = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_v_reg <= 1'b0;
        end
        else if (en)
        begin
            prep_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_reg <= prep_next;
        end
    end

    cia_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_v_reg),
        .in_item   (prep_reg),
        .out_valid (mul_v),
        .out_item  (mul_item)
    );

    cia_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mul_v),
        .in_item   (mul_item),
        .out_valid (div_v),
        .out_item  (div_item)
    );

    // apply sign to products and quotients, zero anything flagged
    always_comb
    begin
        if (div_item.ovf || div_item.dbz)
        begin
            out_value_next = '0;
        end
        else if ((div_item.opcode == OP_MUL || div_item.opcode == OP_DIV) && div_item.neg)
        begin
            out_value_next = -div_item.value;
        end
        else
        begin
            out_value_next = div_item.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= div_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_value_reg <= out_value_next;
            out_ovf_reg   <= div_item.ovf;
            out_dbz_reg   <= div_item.dbz;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = {out_dbz_reg, out_ovf_reg};

`ifndef ASSERT_OFF
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (out_ovf_reg || out_dbz_reg) |-> out_value_reg == '0)
        else $error("flagged result not zero");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(out_ovf_reg && out_dbz_reg))
        else $error("overflow and divide-by-zero both set");

    a_dbz_div_only: assert property (@(posedge clk) disable iff (!rst_n)
        div_v && div_item.dbz |-> div_item.opcode == OP_DIV)
        else $error("divide-by-zero on non-divide item");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(prep_reg) && $stable(out_value_reg))
        else $error("pipeline moved during stall");
`endif

endmodule

### hdl/cia_mul.sv
// three-stage unsigned 64x64 multiplier with overflow check on the magnitudes
// depends on cia_pkg
`timescale 1ns / 1ps

module cia_mul
    import cia_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  item_t in_item,
    output logic  out_valid,
    output item_t out_item
);

    // stage 1: four 32x32 partial products
    logic              v1_reg;
    item_t             item1_reg;
    logic [DATA_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg;
    // stage 2: column sums
    logic              v2_reg;
    item_t             item2_reg;
    logic [HALF_W-1:0] lo_low_reg;
    logic [HALF_W+1:0] mid_reg;
    logic [DATA_W:0]   hi_reg;
    // stage 3: product and range check
    logic              v3_reg;
    item_t             item3_reg;

    logic [DATA_W-1:0] a_lo, a_hi, b_lo, b_hi;
    logic [HALF_W+1:0] mid_next;
    logic [DATA_W:0]   hi_next;
    logic [DATA_W-1:0] lo;
    logic              mul_ovf;
    item_t             item3_next;

    // operand halves, zero extended to the product width
    assign a_lo = {{HALF_W{1'b0}}, in_item.mag_a[HALF_W-1:0]};
    assign a_hi = {{HALF_W{1'b0}}, in_item.mag_a[DATA_W-1:HALF_W]};
    assign b_lo = {{HALF_W{1'b0}}, in_item.mag_b[HALF_W-1:0]};
    assign b_hi = {{HALF_W{1'b0}}, in_item.mag_b[DATA_W-1:HALF_W]};

    always_comb
    begin
        mid_next = {2'b00, p0_reg[DATA_W-1:HALF_W]}
                 + {2'b00, p1_reg[HALF_W-1:0]}
                 + {2'b00, p2_reg[HALF_W-1:0]};
        hi_next  = {1'b0, p3_reg}
                 + {{(HALF_W+1){1'b0}}, p1_reg[DATA_W-1:HALF_W]}
                 + {{(HALF_W+1){1'b0}}, p2_reg[DATA_W-1:HALF_W]};
    end

    always_comb
    begin
        lo = {mid_reg[HALF_W-1:0], lo_low_reg};
        // negative results may reach exactly 2^63
        mul_ovf = (hi_reg != '0) || (mid_reg[HALF_W+1:HALF_W] != 2'b00)
                || (item2_reg.neg ? (lo[DATA_W-1] && (lo[DATA_W-2:0] != '0))
                                  : lo[DATA_W-1]);
        item3_next = item2_reg;
        if (item2_reg.opcode == OP_MUL)
        begin
            item3_next.value = lo;
            item3_next.ovf   = mul_ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item1_reg  <= in_item;
            p0_reg     <= a_lo * b_lo;
            p1_reg     <= a_lo * b_hi;
            p2_reg     <= a_hi * b_lo;
            p3_reg     <= a_hi * b_hi;
            item2_reg  <= item1_reg;
            lo_low_reg <= p0_reg[HALF_W-1:0];
            mid_reg    <= mid_next;
            hi_reg     <= hi_next;
            item3_reg  <= item3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = item3_reg;

endmodule

### hdl/cia_div.sv
// 64-stage restoring divider, one quotient bit per stage
// depends on cia_pkg
`timescale 1ns / 1ps

module cia_div
    import cia_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  item_t in_item,
    output logic  out_valid,
    output item_t out_item
);

    localparam int unsigned STEPS = DATA_W;

    logic              vld_reg  [STEPS];
    item_t             item_reg [STEPS];
    logic [DATA_W-1:0] rem_reg  [STEPS];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic              v_in;
        item_t             it_in;
        logic [DATA_W-1:0] r_in;
        logic [DATA_W-1:0] r_sh;
        logic              ge;
        item_t             item_next;
        logic [DATA_W-1:0] rem_next;

        if (k == 0)
        begin : g_first
            assign v_in  = in_valid;
            assign it_in = in_item;
            assign r_in  = '0;
        end
        else
        begin : g_rest
            assign v_in  = vld_reg[k-1];
            assign it_in = item_reg[k-1];
            assign r_in  = rem_reg[k-1];
        end

        // for a nonzero divisor the remainder stays below the divisor, so the shift never overflows
        always_comb
        begin
            r_sh      = {r_in[DATA_W-2:0], it_in.mag_a[DATA_W-1]};
            ge        = (r_sh >= it_in.mag_b);
            rem_next  = ge ? (r_sh - it_in.mag_b) : r_sh;
            item_next = it_in;
            item_next.mag_a = {it_in.mag_a[DATA_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                item_reg[k] <= item_next;
                rem_reg[k]  <= rem_next;
            end
        end
    end

    // quotient sits in mag_a after the last step
    always_comb
    begin
        out_item = item_reg[STEPS-1];
        if (item_reg[STEPS-1].opcode == OP_DIV)
        begin
            out_item.value = item_reg[STEPS-1].mag_a;
        end
    end

    assign out_valid = vld_reg[STEPS-1];

endmodule
